// ===== hdl/lppd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

   // Packet framing
   localparam logic [23:0] HEADER_HEAD  = 24'h55AA23;
   localparam logic [7:0]  HEADER_LAST  = 8'h10;
   localparam int          SAMPLES      = 16;
   localparam int          DIST_WIDTH   = 14;

   localparam logic [5:0] POS_FIRST    = 6'd4;
   localparam logic [5:0] POS_SPEED_LO = 6'd4;
   localparam logic [5:0] POS_SPEED_HI = 6'd5;
   localparam logic [5:0] POS_START_LO = 6'd6;
   localparam logic [5:0] POS_START_HI = 6'd7;
   localparam logic [5:0] POS_SAMPLE_0 = 6'd8;
   localparam logic [5:0] POS_SAMPLE_E = 6'd56;
   localparam logic [5:0] POS_END_LO   = 6'd56;
   localparam logic [5:0] POS_END_HI   = 6'd57;
   localparam logic [5:0] POS_LAST     = 6'd59;

   // Angle word conversion: trunc((raw - 40960) / 64) must land below 360
   localparam logic [15:0] ANGLE_OFFSET = 16'd40960;
   localparam logic [15:0] ANGLE_LOW    = 16'd40897;
   localparam logic [15:0] ANGLE_HIGH   = 16'd63999;
   localparam logic [9:0]  DEG_FULL     = 10'd360;

   // floor(n / 15) = (n * 8739) >> 17 for every n up to 15 * 359
   localparam logic [15:0] RECIP_15     = 16'd8739;
   localparam int          RECIP_SHIFT  = 17;

   localparam logic [14:0] MAX_DIST_RESET = 15'd10000;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] start_word;
      logic [15:0] end_word;
   } lppd_pkt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_QUOT,
      ST_DEG,
      ST_TRIG,
      ST_MULX,
      ST_MULY,
      ST_LOAD
   } lppd_state_type;

   // round(32768 * sin(k degrees)), k = 0..90
   function automatic logic [15:0] sin_lookup(input logic [6:0] k);
      logic [15:0] v;
      case (k)
         7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
         7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
         7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
         7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
         7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
         7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
         7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
         7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
         7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
         7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
         7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
         7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
         7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
         7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
         7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
         7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
         7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
         7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
         7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
         7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
         7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
         7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
         7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
         7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
         7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
         7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
         7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
         7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
         7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
         7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
         7'd90: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lidar_packet_point_decoder_core.sv =====
// LiDAR packet decoder: takes the sensor's serial stream one byte per transaction,
// finds the 55 AA 23 10 header, gathers the 60-byte packet and turns its sixteen
// samples into points (interpolated whole degree, x and y by Q1.15 cosine and sine,
// range flag, sample index, raw speed word, last flag). The CRC is not checked, and a
// packet with an angle of 360 or more gives no points. Bytes are taken one per cycle
// while framing. After the final packet byte the input is stalled while the packet is
// decoded: a check step that may drop the packet, then per point the quotient, degree,
// trig, x multiply, y multiply and load states, plus any result-side stall. The steps
// per point are set by the one shared 14x16 multiplier, used three times per point (the
// divide by 15 as a reciprocal multiply, then d*cos and d*sin). max_distance is written
// through the csr_ port, which is always ready; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module lidar_packet_point_decoder_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [8:0]         rsp_degree,
   output logic signed [15:0]      rsp_pos_x,
   output logic signed [15:0]      rsp_pos_y,
   output logic                    rsp_in_range,
   output logic      [3:0]         rsp_sample_index,
   output logic      [15:0]        rsp_speed_raw,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [14:0]        csr_max_distance
);

   logic                   byte_accept;
   logic                   pkt_done;
   lppd_pkg::lppd_pkt_type pkt;
   logic [3:0]             rd_addr;
   logic [13:0]            rd_data;
   logic                   mul_en;
   logic [13:0]            mul_a;
   logic [15:0]            mul_b;
   logic [29:0]            product;
   logic                   busy;
   logic [14:0]            max_distance_ff, max_distance_in;

   assign csr_ready   = 1'b1;
   assign req_stall   = busy;
   assign byte_accept = req_valid && !req_stall;

   assign max_distance_in = (csr_valid && csr_ready) ? csr_max_distance : max_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= lppd_pkg::MAX_DIST_RESET;
      end else begin
         max_distance_ff <= max_distance_in;
      end
   end

   lppd_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_accept),
      .byte_data  (req_rx_byte),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .pkt        (pkt),
      .pkt_done   (pkt_done)
   );

   lppd_mul u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   lppd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (pkt_done),
      .pkt              (pkt),
      .max_distance     (max_distance_ff),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .mul_en           (mul_en),
      .mul_a            (mul_a),
      .mul_b            (mul_b),
      .product          (product),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_degree       (rsp_degree),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_in_range     (rsp_in_range),
      .rsp_sample_index (rsp_sample_index),
      .rsp_speed_raw    (rsp_speed_raw),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // the decoder must block the byte stream right after a packet closes
   a_stall_after_packet: assert property (@(posedge clock) disable iff (reset)
      pkt_done |=> req_stall)
      else $error("input not stalled after final packet byte");

   a_last_is_final_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sample_index == 4'(lppd_pkg::SAMPLES - 1))
      else $error("last flag on a sample other than the final one");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_pos_x == 16'sd0 && rsp_pos_y == 16'sd0)
      else $error("non-zero point for an out-of-range distance");

   a_degree_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_degree < 9'd360)
      else $error("interpolated angle not wrapped below 360");
`endif

endmodule

`default_nettype wire

// ===== hdl/lppd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppd_mul (
   input  wire logic        clock,
   input  wire logic        mul_en,
   input  wire logic [13:0] mul_a,
   input  wire logic [15:0] mul_b,
   output logic      [29:0] product
);

   logic [29:0] product_ff;
   logic [29:0] product_in;

   // hold the last product until the next operation is issued
   assign product_in = mul_en ? (30'(mul_a) * 30'(mul_b)) : product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== hdl/lppd_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppd_rx (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_valid,
   input  wire logic [7:0]           byte_data,
   input  wire logic [3:0]           rd_addr,
   output logic      [13:0]          rd_data,
   output lppd_pkg::lppd_pkt_type    pkt,
   output logic                      pkt_done
);

   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;

   logic        collecting_ff, collecting_in;
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] window_ff, window_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] end_ff, end_in;
   logic [3:0]  k_ff, k_in;
   logic [1:0]  phase_ff, phase_in;
   logic        wr_en;
   logic [13:0] rd_data_ff;
   logic [13:0] dist_mem [lppd_pkg::SAMPLES];

   always_comb begin
      collecting_in = collecting_ff;
      pos_in        = pos_ff;
      window_in     = window_ff;
      low_in        = low_ff;
      speed_in      = speed_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      k_in          = k_ff;
      phase_in      = phase_ff;
      wr_en         = 1'b0;
      pkt_done      = 1'b0;
      if (byte_valid) begin
         if (!collecting_ff) begin
            if (window_ff == lppd_pkg::HEADER_HEAD && byte_data == lppd_pkg::HEADER_LAST) begin
               collecting_in = 1'b1;
               pos_in        = lppd_pkg::POS_FIRST;
               window_in     = '0;
            end else begin
               window_in = {window_ff[15:0], byte_data};
            end
         end else begin
            case (pos_ff) inside
               lppd_pkg::POS_SPEED_LO, lppd_pkg::POS_START_LO, lppd_pkg::POS_END_LO: begin
                  low_in = byte_data;
               end
               lppd_pkg::POS_SPEED_HI: begin
                  speed_in = {byte_data, low_ff};
               end
               lppd_pkg::POS_START_HI: begin
                  start_in = {byte_data, low_ff};
                  k_in     = '0;
                  phase_in = PH_LOW;
               end
               lppd_pkg::POS_END_HI: begin
                  end_in = {byte_data, low_ff};
               end
               default: begin
                  if (pos_ff >= lppd_pkg::POS_SAMPLE_0 && pos_ff < lppd_pkg::POS_SAMPLE_E) begin
                     case (phase_ff)
                        PH_LOW: begin
                           low_in   = byte_data;
                           phase_in = PH_HIGH;
                        end
                        PH_HIGH: begin
                           wr_en    = 1'b1;
                           phase_in = PH_SKIP;
                        end
                        default: begin
                           phase_in = PH_LOW;
                           k_in     = 4'(k_ff + 4'd1);
                        end
                     endcase
                  end
               end
            endcase
            if (pos_ff == lppd_pkg::POS_LAST) begin
               collecting_in = 1'b0;
               pos_in        = '0;
               pkt_done      = 1'b1;
            end else begin
               pos_in = 6'(pos_ff + 6'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         pos_ff        <= '0;
         window_ff     <= '0;
      end else begin
         collecting_ff <= collecting_in;
         pos_ff        <= pos_in;
         window_ff     <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      speed_ff <= speed_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      k_ff     <= k_in;
      phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[k_ff] <= {byte_data[5:0], low_ff};
      end
      rd_data_ff <= dist_mem[rd_addr];
   end

   assign rd_data        = rd_data_ff;
   assign pkt.speed      = speed_ff;
   assign pkt.start_word = start_ff;
   assign pkt.end_word   = end_ff;

endmodule

`default_nettype wire

// ===== hdl/lppd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppd_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire lppd_pkg::lppd_pkt_type   pkt,
   input  wire logic [14:0]              max_distance,
   output logic      [3:0]               rd_addr,
   input  wire logic [13:0]              rd_data,
   output logic                          mul_en,
   output logic      [13:0]              mul_a,
   output logic      [15:0]              mul_b,
   input  wire logic [29:0]              product,
   output logic                          busy,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [8:0]               rsp_degree,
   output logic signed [15:0]            rsp_pos_x,
   output logic signed [15:0]            rsp_pos_y,
   output logic                          rsp_in_range,
   output logic      [3:0]               rsp_sample_index,
   output logic      [15:0]              rsp_speed_raw,
   output logic                          rsp_last
);

   lppd_pkg::lppd_state_type state_ff, state_in;

   logic [3:0]  i_ff, i_in;
   logic [12:0] n_ff, n_in;
   logic [8:0]  begin_ff, begin_in;
   logic [8:0]  delta_ff, delta_in;
   logic [8:0]  deg_ff, deg_in;
   logic [13:0] d_ff, d_in;
   logic        inr_ff, inr_in;
   logic [15:0] cmag_ff, cmag_in;
   logic [15:0] smag_ff, smag_in;
   logic        cneg_ff, cneg_in;
   logic        sneg_ff, sneg_in;
   logic [15:0] x_ff, x_in;

   logic        out_valid_ff, out_valid_in;
   logic [8:0]  out_degree_ff, out_degree_in;
   logic [15:0] out_x_ff, out_x_in;
   logic [15:0] out_y_ff, out_y_in;
   logic        out_inr_ff, out_inr_in;
   logic [3:0]  out_index_ff, out_index_in;
   logic [15:0] out_speed_ff, out_speed_in;
   logic        out_last_ff, out_last_in;

   logic        out_free;
   logic        begin_ok, end_ok;
   logic [8:0]  begin_deg, end_deg;
   logic [9:0]  deg_sum;
   logic [8:0]  quot;
   logic [8:0]  s_idx, c_idx;
   logic [14:0] proj_mag;
   logic [15:0] proj_val;

   // trunc((raw - 40960) / 64); only values inside the window count as angles
   function automatic logic [9:0] angle_conv(input logic [15:0] raw);
      logic [15:0] diff;
      logic        ok;
      logic [8:0]  deg;
      diff = 16'(raw - lppd_pkg::ANGLE_OFFSET);
      ok   = (raw >= lppd_pkg::ANGLE_LOW) && (raw <= lppd_pkg::ANGLE_HIGH);
      deg  = (raw >= lppd_pkg::ANGLE_OFFSET) ? diff[14:6] : 9'd0;
      return {ok, deg};
   endfunction

   assign {begin_ok, begin_deg} = angle_conv(pkt.start_word);
   assign {end_ok, end_deg}     = angle_conv(pkt.end_word);

   assign quot     = product[lppd_pkg::RECIP_SHIFT +: 9];
   assign deg_sum  = {1'b0, begin_ff} + {1'b0, quot};
   assign proj_mag = product[29:15];
   assign out_free = !out_valid_ff || !rsp_stall;
   assign rd_addr  = i_ff;
   assign busy     = (state_ff != lppd_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      n_in          = n_ff;
      begin_in      = begin_ff;
      delta_in      = delta_ff;
      deg_in        = deg_ff;
      d_in          = d_ff;
      inr_in        = inr_ff;
      cmag_in       = cmag_ff;
      smag_in       = smag_ff;
      cneg_in       = cneg_ff;
      sneg_in       = sneg_ff;
      x_in          = x_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_degree_in = out_degree_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_inr_in    = out_inr_ff;
      out_index_in  = out_index_ff;
      out_speed_in  = out_speed_ff;
      out_last_in   = out_last_ff;
      mul_en        = 1'b0;
      mul_a         = d_ff;
      mul_b         = cmag_ff;
      s_idx         = '0;
      c_idx         = '0;

      // sign-apply the projection that sits in the multiplier output
      proj_val = {1'b0, proj_mag};

      unique case (state_ff)
         lppd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lppd_pkg::ST_CHECK;
            end
         end
         lppd_pkg::ST_CHECK: begin
            // drop the packet when either angle is out of range
            if (begin_ok && end_ok) begin
               begin_in = begin_deg;
               delta_in = (end_deg >= begin_deg) ? 9'(end_deg - begin_deg)
                                                 : 9'({1'b0, end_deg} + lppd_pkg::DEG_FULL
                                                      - {1'b0, begin_deg});
               i_in     = '0;
               n_in     = '0;
               state_in = lppd_pkg::ST_QUOT;
            end else begin
               state_in = lppd_pkg::ST_IDLE;
            end
         end
         lppd_pkg::ST_QUOT: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, n_ff};
            mul_b    = lppd_pkg::RECIP_15;
            state_in = lppd_pkg::ST_DEG;
         end
         lppd_pkg::ST_DEG: begin
            deg_in   = (deg_sum >= lppd_pkg::DEG_FULL) ? 9'(deg_sum - lppd_pkg::DEG_FULL)
                                                       : deg_sum[8:0];
            d_in     = rd_data;
            inr_in   = (rd_data != 14'd0) && ({1'b0, rd_data} < max_distance);
            state_in = lppd_pkg::ST_TRIG;
         end
         lppd_pkg::ST_TRIG: begin
            if (deg_ff <= 9'd90) begin
               s_idx   = deg_ff;
               c_idx   = 9'(9'd90 - deg_ff);
               sneg_in = 1'b0;
               cneg_in = 1'b0;
            end else if (deg_ff <= 9'd180) begin
               s_idx   = 9'(9'd180 - deg_ff);
               c_idx   = 9'(deg_ff - 9'd90);
               sneg_in = 1'b0;
               cneg_in = 1'b1;
            end else if (deg_ff <= 9'd270) begin
               s_idx   = 9'(deg_ff - 9'd180);
               c_idx   = 9'(9'd270 - deg_ff);
               sneg_in = 1'b1;
               cneg_in = 1'b1;
            end else begin
               s_idx   = 9'(9'd360 - deg_ff);
               c_idx   = 9'(deg_ff - 9'd270);
               sneg_in = 1'b1;
               cneg_in = 1'b0;
            end
            smag_in  = lppd_pkg::sin_lookup(s_idx[6:0]);
            cmag_in  = lppd_pkg::sin_lookup(c_idx[6:0]);
            state_in = lppd_pkg::ST_MULX;
         end
         lppd_pkg::ST_MULX: begin
            mul_en   = 1'b1;
            mul_a    = d_ff;
            mul_b    = cmag_ff;
            state_in = lppd_pkg::ST_MULY;
         end
         lppd_pkg::ST_MULY: begin
            mul_en = 1'b1;
            mul_a  = d_ff;
            mul_b  = smag_ff;
            if (cneg_ff) begin
               proj_val = 16'(~{1'b0, proj_mag} + 16'd1);
            end
            x_in     = inr_ff ? proj_val : 16'd0;
            state_in = lppd_pkg::ST_LOAD;
         end
         lppd_pkg::ST_LOAD: begin
            if (sneg_ff) begin
               proj_val = 16'(~{1'b0, proj_mag} + 16'd1);
            end
            // hold the point until the output register is free
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_degree_in = deg_ff;
               out_x_in      = x_ff;
               out_y_in      = inr_ff ? proj_val : 16'd0;
               out_inr_in    = inr_ff;
               out_index_in  = i_ff;
               out_speed_in  = pkt.speed;
               out_last_in   = (i_ff == 4'(lppd_pkg::SAMPLES - 1));
               if (i_ff == 4'(lppd_pkg::SAMPLES - 1)) begin
                  state_in = lppd_pkg::ST_IDLE;
               end else begin
                  i_in     = 4'(i_ff + 4'd1);
                  n_in     = 13'(n_ff + {4'd0, delta_ff});
                  state_in = lppd_pkg::ST_QUOT;
               end
            end
         end
         default: begin
            state_in = lppd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lppd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      n_ff          <= n_in;
      begin_ff      <= begin_in;
      delta_ff      <= delta_in;
      deg_ff        <= deg_in;
      d_ff          <= d_in;
      inr_ff        <= inr_in;
      cmag_ff       <= cmag_in;
      smag_ff       <= smag_in;
      cneg_ff       <= cneg_in;
      sneg_ff       <= sneg_in;
      x_ff          <= x_in;
      out_degree_ff <= out_degree_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_inr_ff    <= out_inr_in;
      out_index_ff  <= out_index_in;
      out_speed_ff  <= out_speed_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_degree       = out_degree_ff;
   assign rsp_pos_x        = out_x_ff;
   assign rsp_pos_y        = out_y_ff;
   assign rsp_in_range     = out_inr_ff;
   assign rsp_sample_index = out_index_ff;
   assign rsp_speed_raw    = out_speed_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ===== verif/lidar_packet_point_decoder_core_test.sv =====
`timescale 1ns / 1ps

module lidar_packet_point_decoder_core_test;

   localparam int unsigned RAW_PER_DEGREE = 64;
   localparam longint unsigned PI_Q32     = 64'd13493037705;
   localparam int DECODE_CYCLES           = 120;
   localparam int LONG_HOLD               = 400;

   typedef struct {
      logic [8:0]         degree;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               in_range;
      logic [3:0]         sample_index;
      logic [15:0]        speed_raw;
      logic               last;
   } point_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte      = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [8:0]         rsp_degree;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic               rsp_in_range;
   logic [3:0]         rsp_sample_index;
   logic [15:0]        rsp_speed_raw;
   logic               rsp_last;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [14:0]        csr_max_distance = 15'd0;

   // predictor state
   logic [23:0] hdr_window  = '0;
   logic [5:0]  pkt_pos     = '0;
   logic        framing     = 1'b0;
   logic [7:0]  low_hold    = '0;
   logic [15:0] speed_word  = '0;
   logic [15:0] start_word  = '0;
   logic [15:0] end_word    = '0;
   logic [13:0] sample_dist [lppd_pkg::SAMPLES];
   logic [14:0] limit_model = lppd_pkg::MAX_DIST_RESET;
   int          sine_q15 [0:90];

   logic [7:0]  pending_bytes [$];
   point_type   expected_points [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   int          hold_asks      = 0;
   int          holds_done     = 0;
   int          hold_left      = 0;

   lidar_packet_point_decoder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_degree       (rsp_degree),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_in_range     (rsp_in_range),
      .rsp_sample_index (rsp_sample_index),
      .rsp_speed_raw    (rsp_speed_raw),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_distance (csr_max_distance)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned sine_q31(input int unsigned k);
      longint unsigned x, x2, pos, neg, term, n;
      x = k;
      x = (x * PI_Q32 + 64'd180) / 64'd360;
      x2 = (x * x) >> 31;
      pos = x;
      neg = 0;
      term = x;
      for (n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 31) / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) neg += term;
         else pos += term;
      end
      return (pos > neg) ? pos - neg : 64'd0;
   endfunction

   function automatic void build_sine_table();
      for (int k = 0; k <= 90; k++)
         sine_q15[k] = int'((sine_q31(k) + 64'd32768) >> 16);
   endfunction

   function automatic void cos_sin(input int a, output int c, output int s);
      if (a <= 90) begin
         s = sine_q15[a];        c = sine_q15[90 - a];
      end else if (a <= 180) begin
         s = sine_q15[180 - a];  c = -sine_q15[a - 90];
      end else if (a <= 270) begin
         s = -sine_q15[a - 180]; c = -sine_q15[270 - a];
      end else begin
         s = -sine_q15[360 - a]; c = sine_q15[a - 270];
      end
   endfunction

   function automatic int scale_distance(input int unsigned d_val, input int t);
      int unsigned mag, prod;
      mag = unsigned'((t < 0) ? -t : t);
      prod = (d_val * mag) >> 15;
      return (t < 0) ? -int'(prod) : int'(prod);
   endfunction

   // trunc((raw - offset) / 64), kept to 16 bits
   function automatic int unsigned packet_angle(input logic [15:0] raw);
      int diff;
      diff = int'(raw) - int'(lppd_pkg::ANGLE_OFFSET);
      diff = diff / int'(RAW_PER_DEGREE);
      return diff & 32'hFFFF;
   endfunction

   task automatic decode_packet();
      int unsigned first_deg, last_deg, span, deg, d_val;
      int          c, s;
      point_type   pt;
      first_deg = packet_angle(start_word);
      last_deg = packet_angle(end_word);
      // drop the packet when either angle is out of range
      if (first_deg >= lppd_pkg::DEG_FULL || last_deg >= lppd_pkg::DEG_FULL) return;
      span = (last_deg + lppd_pkg::DEG_FULL - first_deg) % lppd_pkg::DEG_FULL;
      for (int i = 0; i < lppd_pkg::SAMPLES; i++) begin
         deg = (first_deg + span * i / (lppd_pkg::SAMPLES - 1)) % lppd_pkg::DEG_FULL;
         d_val = sample_dist[i];
         pt.degree = deg[8:0];
         pt.in_range = (d_val != 0) && (d_val < limit_model);
         pt.pos_x = '0;
         pt.pos_y = '0;
         if (pt.in_range) begin
            cos_sin(deg, c, s);
            pt.pos_x = 16'(scale_distance(d_val, c));
            pt.pos_y = 16'(scale_distance(d_val, s));
         end
         pt.sample_index = i[3:0];
         pt.speed_raw = speed_word;
         pt.last = (i == lppd_pkg::SAMPLES - 1);
         expected_points.push_back(pt);
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      logic [5:0]  p;
      int unsigned offs;
      if (!framing) begin
         if (hdr_window == lppd_pkg::HEADER_HEAD && b == lppd_pkg::HEADER_LAST) begin
            framing = 1'b1;
            pkt_pos = lppd_pkg::POS_FIRST;
            hdr_window = '0;
         end else begin
            hdr_window = {hdr_window[15:0], b};
         end
         return;
      end
      p = pkt_pos;
      if (p == lppd_pkg::POS_SPEED_LO || p == lppd_pkg::POS_START_LO
          || p == lppd_pkg::POS_END_LO) begin
         low_hold = b;
      end else if (p == lppd_pkg::POS_SPEED_HI) begin
         speed_word = {b, low_hold};
      end else if (p == lppd_pkg::POS_START_HI) begin
         start_word = {b, low_hold};
      end else if (p == lppd_pkg::POS_END_HI) begin
         end_word = {b, low_hold};
      end else if (p >= lppd_pkg::POS_SAMPLE_0 && p < lppd_pkg::POS_SAMPLE_E) begin
         // each sample: distance low, distance high, one unused byte
         offs = p - lppd_pkg::POS_SAMPLE_0;
         if (offs % 3 == 0) low_hold = b;
         else if (offs % 3 == 1) sample_dist[offs / 3] = {b[5:0], low_hold};
      end
      if (p != lppd_pkg::POS_LAST) begin
         pkt_pos = p + 6'd1;
         return;
      end
      framing = 1'b0;
      pkt_pos = '0;
      decode_packet();
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) take_byte(req_rx_byte);
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_point();
      point_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: unexpected point, expected none, actual degree %0d index %0d",
                  $time, rsp_degree, rsp_sample_index);
         mismatch_count++;
         return;
      end
      want = expected_points.pop_front();
      compare_field("degree", want.degree, rsp_degree);
      compare_field("pos_x", want.pos_x, rsp_pos_x);
      compare_field("pos_y", want.pos_y, rsp_pos_y);
      compare_field("in_range", want.in_range, rsp_in_range);
      compare_field("sample_index", want.sample_index, rsp_sample_index);
      compare_field("speed_raw", want.speed_raw, rsp_speed_raw);
      compare_field("last", want.last, rsp_last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_point();
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != holds_done) begin
         // long hold-off: let the block back up into its input
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_max_distance(input logic [14:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_max_distance <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_model = value;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
   endtask

   // a dropped packet gives nothing to wait for, so allow a full decode afterwards
   task automatic settle();
      wait_drained();
      repeat (DECODE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] sample_word(input int idx, input bit directed);
      logic [13:0] d;
      int          sel;
      sel = directed ? idx % 8 : $urandom_range(0, 7);
      case (sel)
         0: d = 14'd0;
         1: d = 14'd1;
         2: d = 14'h3FFF;
         3: d = 14'(limit_model - 15'd1);
         4: d = 14'(limit_model);
         5: d = 14'(limit_model + 15'd1);
         6: d = 14'($urandom_range(1, 255));
         default: d = 14'($urandom);
      endcase
      // garbage in the two top bits must be masked off
      return {2'($urandom_range(0, 3)), d};
   endfunction

   task automatic queue_packet(input logic [15:0] speed, input logic [15:0] start_raw,
                               input logic [15:0] end_raw, input bit directed,
                               input logic [15:0] crc);
      logic [15:0] w;
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[23:16]);
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[15:8]);
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[7:0]);
      pending_bytes.push_back(lppd_pkg::HEADER_LAST);
      pending_bytes.push_back(speed[7:0]);
      pending_bytes.push_back(speed[15:8]);
      pending_bytes.push_back(start_raw[7:0]);
      pending_bytes.push_back(start_raw[15:8]);
      for (int i = 0; i < lppd_pkg::SAMPLES; i++) begin
         w = sample_word(i, directed);
         pending_bytes.push_back(w[7:0]);
         pending_bytes.push_back(w[15:8]);
         pending_bytes.push_back(8'($urandom));
      end
      pending_bytes.push_back(end_raw[7:0]);
      pending_bytes.push_back(end_raw[15:8]);
      pending_bytes.push_back(crc[7:0]);
      pending_bytes.push_back(crc[15:8]);
   endtask

   function automatic logic [15:0] good_angle_raw();
      return 16'($urandom_range(lppd_pkg::ANGLE_LOW, lppd_pkg::ANGLE_HIGH));
   endfunction

   task automatic queue_broken_header();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == lppd_pkg::HEADER_LAST) b = ~b;
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[23:16]);
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[15:8]);
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[7:0]);
      pending_bytes.push_back(b);
   endtask

   task automatic set_pace(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
   endtask

   initial begin
      logic [14:0] lim;
      build_sine_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // limit left at its reset value: full sweep 0..359, CRC tail and noise
      // that look like a header
      @(negedge clock);
      set_pace(14, 58);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      queue_broken_header();
      queue_packet(16'h0000, lppd_pkg::ANGLE_LOW, lppd_pkg::ANGLE_HIGH, 1'b1,
                   {lppd_pkg::HEADER_HEAD[15:8], lppd_pkg::HEADER_HEAD[23:16]});
      pending_bytes.push_back(lppd_pkg::HEADER_HEAD[7:0]);
      pending_bytes.push_back(lppd_pkg::HEADER_LAST);
      // sender holds back until every point is out
      settle();

      // wrap through zero while the receiver holds off; bytes behind it back up
      write_max_distance(15'd16384);
      @(negedge clock);
      set_pace(58, 14);
      hold_asks++;
      queue_packet(16'hFFFF, lppd_pkg::ANGLE_HIGH, lppd_pkg::ANGLE_OFFSET, 1'b1, 16'hFFFF);
      queue_broken_header();
      settle();

      lim = 15'($urandom_range(1, 3000));
      write_max_distance(lim);
      @(negedge clock);
      set_pace(0, 0);
      queue_packet(16'($urandom), good_angle_raw(), good_angle_raw(), 1'b0,
                   16'($urandom));
      settle();

      if (expected_points.size() != 0) begin
         $display("%0t: %0d points never arrived, expected none left, actual %0d",
                  $time, expected_points.size(), expected_points.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
